>>> src/psm_pkg.sv
// Package: sizes, codes and shared types of the pose sequence prefix matcher.
package psm_pkg;

	localparam int GESTURES  = 8;
	localparam int SLOTS     = 4;
	localparam int MAX_LEN   = 8;
	localparam int POSE_BITS = 8;
	localparam int NSLOTS    = GESTURES * SLOTS;
	localparam int POS_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int SLOT_W    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int GEST_W    = (GESTURES > 1) ? $clog2(GESTURES) : 1;
	localparam int SLOTIX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		REQ_OBSERVE = 2'd0,
		REQ_CLEAR   = 2'd1,
		REQ_TIMER   = 2'd2,
		REQ_WRITE   = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		KIND_UNCONFIRMED = 2'd0,
		KIND_IDLE        = 2'd1,
		KIND_REGULAR     = 2'd2,
		KIND_UNKNOWN     = 2'd3
	} kind_code_t;

	typedef enum logic [3:0] {
		ACT_NO_PREFIX    = 4'd0,
		ACT_IDLE_RESET   = 4'd1,
		ACT_IDLE_COMMIT  = 4'd2,
		ACT_IDLE_DISCARD = 4'd3,
		ACT_LIVE_PREFIX  = 4'd4,
		ACT_COMMIT_NOW   = 4'd5,
		ACT_START_TIMER  = 4'd6,
		ACT_TIMER_SET    = 4'd7,
		ACT_ACK          = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_LOAD,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] cluster_kind;
		logic [7:0] pose_id;
		logic [7:0] candidate_mask;
		logic [2:0] tmpl_gesture;
		logic [1:0] tmpl_slot;
		logic [2:0] tmpl_pos;
		logic [7:0] tmpl_pose;
		logic [3:0] tmpl_length;
	} req_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] gesture_mask;
		logic [7:0] exact_now_mask;
		logic [3:0] observed_length;
	} res_t;

	// template write into one cell
	typedef struct packed {
		logic                 en;
		logic [POS_W-1:0]     pos;
		logic [POSE_BITS-1:0] pose;
		logic [LEN_W-1:0]     len;
	} cell_wr_t;

	// broadcast compare step
	typedef struct packed {
		logic                 start;
		logic                 step;
		logic [POS_W-1:0]     pos;
		logic [POSE_BITS-1:0] pose;
		logic                 load;
		logic                 shift;
	} cell_ctl_t;

	// per-slot summary handed down the chain
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] lcp;
	} slot_info_t;

endpackage

>>> src/psm_cell.sv
// One template slot: stores its poses and length, tracks the common prefix length.
module psm_cell import psm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_wr_t   wr,
	input  cell_ctl_t  ctl,
	input  slot_info_t chain_in,
	output slot_info_t chain_out
);

	logic [POSE_BITS-1:0] poses_q [MAX_LEN];
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     lcp_q;
	logic                 going_q;
	slot_info_t           info_q;
	logic                 hit;

	// position still inside template and pose equal
	assign hit = going_q && ({{(LEN_W-POS_W){1'b0}}, ctl.pos} < len_q)
		&& (poses_q[ctl.pos] == ctl.pose);

	// template storage
	always_ff @(posedge clk) begin
		if (wr.en) begin
			poses_q[wr.pos] <= wr.pose;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			lcp_q   <= '0;
			going_q <= 1'b0;
		end else begin
			if (wr.en) begin
				len_q <= wr.len;
			end
			if (ctl.start) begin
				lcp_q   <= '0;
				going_q <= 1'b1;
			end else if (ctl.step) begin
				if (hit) begin
					lcp_q <= LEN_W'({{(LEN_W-POS_W){1'b0}}, ctl.pos} + 1'b1);
				end else begin
					going_q <= 1'b0;
				end
			end
		end
	end

	// summary shift register along the chain
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			info_q.len <= len_q;
			info_q.lcp <= lcp_q;
		end else if (ctl.shift) begin
			info_q <= chain_in;
		end
	end

	assign chain_out = info_q;

endmodule

>>> src/pose_sequence_prefix_matcher.sv
// Top level: request sequencer, observed sequence and the row of slot cells.
// From start to the done strobe, every slot cell first compares one pose position
// per cycle in parallel, then the slot summaries are loaded and shift out of the cell
// row one per cycle into the gesture accumulators, and the result is registered.
// busy is high while the item is in work and falls as done rises; the result is on
// res for the single cycle that done is high and must be taken then.
module pose_sequence_prefix_matcher import psm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t res
);

	state_t state_q, state_d;
	req_t   req_q;
	logic   accept;

	logic [POSE_BITS-1:0] obs_q [MAX_LEN];
	logic [LEN_W-1:0]     count_q;
	logic [LEN_W-1:0]     n_q;
	logic [POS_W-1:0]     pos_q;
	logic [SLOT_W-1:0]    d_cnt_q;
	logic [GEST_W-1:0]    g_cnt_q;
	logic [SLOTIX_W-1:0]  s_cnt_q;

	logic [GESTURES-1:0] exn_q, exo_q, loaded_q, okm_q, anc_q;
	logic [LEN_W-1:0]    best_q;
	logic                any_q, longer_q;

	cell_wr_t   wr;
	cell_ctl_t  ctl;
	slot_info_t chain [NSLOTS+1];
	slot_info_t head;

	logic                 done_q;
	res_t                 res_q;
	logic [SLOT_W-1:0]    wr_slot;
	logic                 wr_ok;
	logic [GESTURES-1:0]  g_bit;
	res_t                 res_d;
	logic                 commit_obs;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign res    = res_q;

	// template write decode
	assign wr_slot = SLOT_W'(SLOT_W'(req.tmpl_gesture) * SLOT_W'(SLOTS)
		+ SLOT_W'(req.tmpl_slot));
	assign wr_ok = ({1'b0, req.tmpl_gesture} < 4'(GESTURES))
		&& ({1'b0, req.tmpl_slot} < 3'(SLOTS))
		&& ({1'b0, req.tmpl_pos} < 4'(MAX_LEN));

	always_comb begin
		wr.en   = accept && (req.req_type == REQ_WRITE) && wr_ok;
		wr.pos  = POS_W'(req.tmpl_pos);
		wr.pose = POSE_BITS'(req.tmpl_pose);
		wr.len  = (req.tmpl_length > 4'(MAX_LEN)) ? LEN_W'(MAX_LEN)
			: LEN_W'(req.tmpl_length);
	end

	// compare broadcast: candidate pose sits at position count
	always_comb begin
		ctl.start = accept;
		ctl.step  = (state_q == ST_CMP);
		ctl.pos   = pos_q;
		ctl.pose  = (({{(LEN_W-POS_W){1'b0}}, pos_q} == count_q)
			&& (req_q.req_type == REQ_OBSERVE)) ? POSE_BITS'(req_q.pose_id)
			: obs_q[pos_q];
		ctl.load  = (state_q == ST_LOAD);
		ctl.shift = (state_q == ST_DRAIN);
	end

	// row of slot cells, summaries leave at cell 0
	assign chain[NSLOTS] = '0;
	for (genvar i = 0; i < NSLOTS; i++) begin : g_cell
		cell_wr_t cwr;
		always_comb begin
			cwr    = wr;
			cwr.en = wr.en && (wr_slot == SLOT_W'(i));
		end
		psm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (cwr),
			.ctl      (ctl),
			.chain_in (chain[i+1]),
			.chain_out(chain[i])
		);
	end
	assign head = chain[0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_CMP;
			ST_CMP:   if (pos_q == POS_W'(MAX_LEN - 1)) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DRAIN;
			ST_DRAIN: if (d_cnt_q == SLOT_W'(NSLOTS - 1)) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign g_bit = {{(GESTURES-1){1'b0}}, 1'b1} << g_cnt_q;

	// result of the finished pass
	always_comb begin
		logic [GESTURES-1:0] v;
		res_d                 = '0;
		commit_obs            = 1'b0;
		v                     = req_q.candidate_mask & loaded_q & okm_q;
		res_d.exact_now_mask  = exo_q;
		res_d.observed_length = 4'(count_q);
		res_d.action          = ACT_NO_PREFIX;
		case (req_q.req_type)
			REQ_OBSERVE: begin
				if (req_q.cluster_kind == KIND_REGULAR) begin
					if ((count_q != LEN_W'(MAX_LEN)) && any_q) begin
						commit_obs            = 1'b1;
						res_d.exact_now_mask  = exn_q;
						res_d.observed_length = 4'(n_q);
						if (exn_q == '0) begin
							res_d.action = ACT_LIVE_PREFIX;
						end else begin
							res_d.gesture_mask = exn_q;
							res_d.action = longer_q ? ACT_START_TIMER : ACT_COMMIT_NOW;
						end
					end
				end else if (req_q.cluster_kind == KIND_IDLE) begin
					if (count_q == '0) begin
						res_d.action = ACT_IDLE_RESET;
					end else if (best_q != '0) begin
						res_d.action       = ACT_IDLE_COMMIT;
						res_d.gesture_mask = anc_q;
					end else begin
						res_d.action       = ACT_IDLE_DISCARD;
						res_d.gesture_mask = loaded_q;
					end
				end
			end
			REQ_TIMER: begin
				res_d.action       = ACT_TIMER_SET;
				res_d.gesture_mask = (v != '0) ? v : req_q.candidate_mask;
			end
			REQ_CLEAR: res_d.action = ACT_ACK;
			REQ_WRITE: res_d.action = ACT_ACK;
			default:   res_d.action = ACT_ACK;
		endcase
	end

	// control registers and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			pos_q    <= '0;
			d_cnt_q  <= '0;
			g_cnt_q  <= '0;
			s_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
			if (accept) begin
				pos_q   <= '0;
				d_cnt_q <= '0;
				g_cnt_q <= '0;
				s_cnt_q <= '0;
				if (req.req_type == REQ_CLEAR) begin
					count_q <= '0;
				end
			end
			if (state_q == ST_CMP) begin
				pos_q <= POS_W'(pos_q + 1'b1);
			end
			if (state_q == ST_DRAIN) begin
				d_cnt_q <= SLOT_W'(d_cnt_q + 1'b1);
				if (s_cnt_q == SLOTIX_W'(SLOTS - 1)) begin
					s_cnt_q <= '0;
					g_cnt_q <= GEST_W'(g_cnt_q + 1'b1);
				end else begin
					s_cnt_q <= SLOTIX_W'(s_cnt_q + 1'b1);
				end
			end
			if ((state_q == ST_DONE) && commit_obs) begin
				count_q <= n_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req;
			n_q      <= (req.req_type == REQ_CLEAR) ? LEN_W'(1)
				: LEN_W'(count_q + 1'b1);
			exn_q    <= '0;
			exo_q    <= '0;
			loaded_q <= '0;
			okm_q    <= '0;
			anc_q    <= '0;
			best_q   <= '0;
			any_q    <= 1'b0;
			longer_q <= 1'b0;
		end
		if (state_q == ST_DRAIN) begin
			if (head.len != '0) begin
				loaded_q <= loaded_q | g_bit;
				if ((head.len >= n_q) && (head.lcp >= n_q)) begin
					any_q <= 1'b1;
					if (head.len > n_q) longer_q <= 1'b1;
				end
				if ((head.len == n_q) && (head.lcp >= n_q)) exn_q <= exn_q | g_bit;
				if ((head.len == count_q) && (head.lcp >= count_q))
					exo_q <= exo_q | g_bit;
				if ((head.len >= count_q) && (head.lcp >= count_q))
					okm_q <= okm_q | g_bit;
				if ((head.len <= count_q) && (head.lcp >= head.len)) begin
					if (head.len > best_q) begin
						best_q <= head.len;
						anc_q  <= g_bit;
					end else if (head.len == best_q) begin
						anc_q <= anc_q | g_bit;
					end
				end
			end
		end
		if (state_q == ST_DONE) begin
			res_q <= res_d;
			if (commit_obs) begin
				obs_q[count_q[POS_W-1:0]] <= POSE_BITS'(req_q.pose_id);
			end
		end
	end

endmodule

>>> src/psm_checker.sv
// Port-level checker for the pose sequence prefix matcher, bound to the top level.
module psm_checker import psm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t res
);

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// a result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// a result follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in work");

	// result codes and length stay in range
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((res.action <= ACT_ACK) && (res.observed_length <= 4'(MAX_LEN))))
		else $error("result field out of range");

endmodule

bind pose_sequence_prefix_matcher psm_checker u_psm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.res   (res)
);

>>> bench/pose_sequence_prefix_matcher_tb.sv
// Testbench: directed and random traffic against a built-in predictor of the matcher.
module pose_sequence_prefix_matcher_tb import psm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	res_t res;

	pose_sequence_prefix_matcher DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .res(res)
	);

	// predictor state
	logic [7:0] tpl_pose [NSLOTS][MAX_LEN];
	logic [3:0] tpl_len [NSLOTS];
	logic [7:0] seq_pose [MAX_LEN];
	logic [3:0] seq_count;
	logic [MAX_LEN-1:0] tpl_written [NSLOTS];

	res_t expected_q [$];
	int fail_count;
	int items_sent;
	int results_seen;
	int sender_idle_pct;
	logic [7:0] alphabet [4];
	int action_hits [9];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// slot s starts with seq[0..n-1]; exact also demands length n
	function automatic bit slot_match(int s, logic [7:0] sq [MAX_LEN], int n, bit exact);
		int len;
		len = tpl_len[s];
		if (len == 0 || len < n || (exact && len != n))
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (tpl_pose[s][i] !== sq[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] gesture_hits(logic [7:0] sq [MAX_LEN], int n, bit exact);
		logic [7:0] m;
		m = '0;
		for (int g = 0; g < GESTURES; g++)
			for (int k = 0; k < SLOTS; k++)
				if (slot_match(g * SLOTS + k, sq, n, exact))
					m[g] = 1'b1;
		return m;
	endfunction

	function automatic logic [7:0] loaded_mask();
		logic [7:0] m;
		m = '0;
		for (int g = 0; g < GESTURES; g++)
			for (int k = 0; k < SLOTS; k++)
				if (tpl_len[g * SLOTS + k] != 0)
					m[g] = 1'b1;
		return m;
	endfunction

	// expected result of one item, updating the predictor state
	function automatic res_t predict_match(req_t r);
		res_t o;
		logic [7:0] cand [MAX_LEN];
		logic [7:0] m;
		int n;
		int s;
		bit any_hit;
		bit longer;
		o = '0;
		o.action = ACT_NO_PREFIX;
		case (req_code_t'(r.req_type))
			REQ_OBSERVE: begin
				if (kind_code_t'(r.cluster_kind) == KIND_IDLE) begin
					if (seq_count == 0) begin
						o.action = ACT_IDLE_RESET;
					end else begin
						o.action = ACT_IDLE_DISCARD;
						o.gesture_mask = loaded_mask();
						for (int len = seq_count; len >= 1; len--) begin
							m = gesture_hits(seq_pose, len, 1'b1);
							if (m != 0) begin
								o.action = ACT_IDLE_COMMIT;
								o.gesture_mask = m;
								break;
							end
						end
					end
				end else if (kind_code_t'(r.cluster_kind) == KIND_REGULAR) begin
					n = seq_count + 1;
					if (n <= MAX_LEN) begin
						cand = seq_pose;
						cand[n - 1] = r.pose_id;
						any_hit = 1'b0;
						longer = 1'b0;
						for (s = 0; s < NSLOTS; s++)
							if (slot_match(s, cand, n, 1'b0)) begin
								any_hit = 1'b1;
								if (tpl_len[s] > n)
									longer = 1'b1;
							end
						if (any_hit) begin
							seq_pose = cand;
							seq_count = 4'(n);
							m = gesture_hits(cand, n, 1'b1);
							if (m == 0) begin
								o.action = ACT_LIVE_PREFIX;
							end else begin
								o.gesture_mask = m;
								o.action = longer ? ACT_START_TIMER : ACT_COMMIT_NOW;
							end
						end
					end
				end
			end
			REQ_CLEAR: begin
				seq_count = '0;
				o.action = ACT_ACK;
			end
			REQ_TIMER: begin
				m = r.candidate_mask & loaded_mask() & gesture_hits(seq_pose, seq_count, 1'b0);
				o.gesture_mask = (m != 0) ? m : r.candidate_mask;
				o.action = ACT_TIMER_SET;
			end
			default: begin
				s = r.tmpl_gesture * SLOTS + r.tmpl_slot;
				tpl_pose[s][r.tmpl_pos] = r.tmpl_pose;
				tpl_len[s] = (r.tmpl_length > MAX_LEN) ? 4'(MAX_LEN) : r.tmpl_length;
				o.action = ACT_ACK;
			end
		endcase
		o.exact_now_mask = gesture_hits(seq_pose, seq_count, 1'b1);
		o.observed_length = seq_count;
		return o;
	endfunction

	// send one item, idling before it at the current rate
	task automatic send_item(req_t r);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		if (r.req_type == REQ_WRITE)
			tpl_written[r.tmpl_gesture * SLOTS + r.tmpl_slot][r.tmpl_pos] = 1'b1;
		expected_q = {expected_q, predict_match(r)};
		items_sent++;
	endtask

	// hold off until every expected result has come
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t rand_req();
		return req_t'({$urandom, $urandom});
	endfunction

	task automatic send_observe(kind_code_t kind, logic [7:0] pose);
		req_t r;
		r = rand_req();
		r.req_type = REQ_OBSERVE;
		r.cluster_kind = kind;
		r.pose_id = pose;
		send_item(r);
	endtask

	task automatic send_simple(req_code_t code, logic [7:0] cmask);
		req_t r;
		r = rand_req();
		r.req_type = code;
		r.candidate_mask = cmask;
		send_item(r);
	endtask

	// write a whole template so no unwritten position is ever inside its length:
	// positions go in with the slot unused, the last write sets the length
	task automatic load_template(int g, int k, int raw_len, logic [7:0] poses [MAX_LEN]);
		req_t r;
		int clamp_len;
		int cnt;
		clamp_len = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;
		cnt = (clamp_len == 0) ? 1 : clamp_len;
		for (int p = 0; p < cnt; p++) begin
			r = rand_req();
			r.req_type = REQ_WRITE;
			r.tmpl_gesture = 3'(g);
			r.tmpl_slot = 2'(k);
			r.tmpl_pos = (clamp_len == 0) ? r.tmpl_pos : 3'(p);
			r.tmpl_pose = poses[p];
			r.tmpl_length = (p == cnt - 1) ? 4'(raw_len) : 4'd0;
			send_item(r);
		end
	endtask

	function automatic logic [7:0] pick_pose();
		return ($urandom_range(9) == 0) ? 8'($urandom) : alphabet[$urandom_range(3)];
	endfunction

	task automatic load_random_template(int g, int k);
		logic [7:0] poses [MAX_LEN];
		int len;
		foreach (poses[i])
			poses[i] = pick_pose();
		len = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
		load_template(g, k, len, poses);
	endtask

	// single write anywhere, length kept safe against unwritten positions
	task automatic send_noise_write();
		req_t r;
		int s;
		int clamp_len;
		logic [MAX_LEN-1:0] after;
		r = rand_req();
		r.req_type = REQ_WRITE;
		s = r.tmpl_gesture * SLOTS + r.tmpl_slot;
		after = tpl_written[s];
		after[r.tmpl_pos] = 1'b1;
		clamp_len = (r.tmpl_length > MAX_LEN) ? MAX_LEN : r.tmpl_length;
		for (int p = 0; p < clamp_len; p++)
			if (!after[p])
				r.tmpl_length = '0;
		send_item(r);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: action %0d", res.action);
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (e.action < 9)
					action_hits[e.action]++;
				if (res.action !== e.action) begin
					$error("action expected %0d actual %0d", e.action, res.action);
					fail_count++;
				end
				if (res.gesture_mask !== e.gesture_mask) begin
					$error("gesture_mask expected %h actual %h", e.gesture_mask,
						res.gesture_mask);
					fail_count++;
				end
				if (res.exact_now_mask !== e.exact_now_mask) begin
					$error("exact_now_mask expected %h actual %h", e.exact_now_mask,
						res.exact_now_mask);
					fail_count++;
				end
				if (res.observed_length !== e.observed_length) begin
					$error("observed_length expected %0d actual %0d", e.observed_length,
						res.observed_length);
					fail_count++;
				end
			end
		end
	end

	// empty table: idle, timer, regular and clear with nothing loaded
	task automatic test_empty_table();
		send_observe(KIND_IDLE, 8'h00);
		send_simple(REQ_TIMER, 8'hFF);
		send_simple(REQ_TIMER, 8'h00);
		send_observe(KIND_REGULAR, 8'hFF);
		send_simple(REQ_CLEAR, 8'h00);
	endtask

	// ignored kinds, full sequence, long length clamp, commit and discard
	task automatic test_directed_sequences();
		logic [7:0] p [MAX_LEN];
		p = '{8'h80, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
		load_template(7, 3, 15, p);
		p = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		load_template(0, 0, 2, p);
		load_template(0, 1, 1, p);
		send_observe(KIND_UNCONFIRMED, 8'hFF);
		send_observe(KIND_UNKNOWN, 8'hFF);
		send_observe(KIND_REGULAR, 8'hFF);
		send_observe(KIND_REGULAR, 8'h00);
		send_observe(KIND_IDLE, 8'h00);
		send_simple(REQ_TIMER, 8'hFF);
		send_simple(REQ_CLEAR, 8'h00);
		for (int i = 0; i < MAX_LEN; i++)
			send_observe(KIND_REGULAR, (i == 0) ? 8'h80 : (i == 1) ? 8'h00 :
				(i == 2) ? 8'hFF : 8'(i - 2));
		send_observe(KIND_REGULAR, 8'h80);
		send_observe(KIND_IDLE, 8'h00);
		send_simple(REQ_CLEAR, 8'h00);
		send_observe(KIND_REGULAR, 8'h80);
		send_observe(KIND_IDLE, 8'h00);
		send_simple(REQ_TIMER, 8'h5A);
	endtask

	// mostly well-formed pose sequences along stored templates, with noise
	task automatic test_random_traffic(int count);
		int goal;
		int s;
		int n;
		int sel;
		goal = items_sent + count;
		foreach (alphabet[i])
			alphabet[i] = 8'($urandom);
		alphabet[0] = 8'h00;
		for (int g = 0; g < GESTURES; g++)
			load_random_template(g, $urandom_range(SLOTS - 1));
		while (items_sent < goal) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				s = -1;
				for (int t = 0; t < 16 && s < 0; t++) begin
					n = $urandom_range(NSLOTS - 1);
					if (tpl_len[n] != 0)
						s = n;
				end
				if (s < 0) begin
					load_random_template($urandom_range(GESTURES - 1),
						$urandom_range(SLOTS - 1));
				end else begin
					if ($urandom_range(4) != 0)
						send_simple(REQ_CLEAR, 8'($urandom));
					n = $urandom_range(1, tpl_len[s]);
					for (int i = 0; i < n; i++)
						send_observe(KIND_REGULAR, ($urandom_range(15) == 0) ?
							pick_pose() : tpl_pose[s][i]);
					if ($urandom_range(1))
						send_observe(KIND_IDLE, 8'($urandom));
					if ($urandom_range(2) == 0)
						send_simple(REQ_TIMER, 8'($urandom));
				end
			end else if (sel < 63) begin
				load_random_template($urandom_range(GESTURES - 1), $urandom_range(SLOTS - 1));
			end else if (sel < 71) begin
				send_noise_write();
			end else if (sel < 85) begin
				send_observe(KIND_REGULAR, pick_pose());
			end else begin
				case ($urandom_range(4))
					0: send_observe(KIND_IDLE, 8'($urandom));
					1: send_simple(REQ_TIMER, 8'($urandom));
					2: send_simple(REQ_CLEAR, 8'($urandom));
					3: send_observe(KIND_UNCONFIRMED, 8'($urandom));
					default: send_observe(KIND_UNKNOWN, 8'($urandom));
				endcase
			end
		end
	endtask

	// overall time limit
	initial begin
		#5ms;
		$display("pose_sequence_prefix_matcher test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		sender_idle_pct = 6;
		seq_count = '0;
		foreach (tpl_len[s]) begin
			tpl_len[s] = '0;
			tpl_written[s] = '0;
			foreach (tpl_pose[s][p])
				tpl_pose[s][p] = '0;
		end
		foreach (seq_pose[i])
			seq_pose[i] = '0;
		foreach (action_hits[i])
			action_hits[i] = 0;
		alphabet = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_sequences();
		drain_results();
		test_random_traffic(400);
		drain_results();
		sender_idle_pct = 54;
		test_random_traffic(400);
		drain_results();
		sender_idle_pct = 0;
		test_random_traffic(420);
		drain_results();
		repeat (60) @(posedge clk);

		$display("Run covered %0d items, %0d results; commits %0d, timers %0d, discards %0d.",
			items_sent, results_seen, action_hits[ACT_COMMIT_NOW],
			action_hits[ACT_START_TIMER], action_hits[ACT_IDLE_DISCARD]);
		$display("Live prefixes %0d, idle commits %0d, no-prefix answers %0d.",
			action_hits[ACT_LIVE_PREFIX], action_hits[ACT_IDLE_COMMIT],
			action_hits[ACT_NO_PREFIX]);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("pose_sequence_prefix_matcher test passed");
		else
			$display("pose_sequence_prefix_matcher test failed");
		$finish;
	end

endmodule

>>> pose_sequence_prefix_matcher.f
src/psm_pkg.sv
src/psm_cell.sv
src/pose_sequence_prefix_matcher.sv
src/psm_checker.sv
bench/pose_sequence_prefix_matcher_tb.sv
